// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the motion activity classifier RTL.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is active (active-low reset).
`define MAC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/mac_pkg.sv =====
// Package for the motion activity classifier: register codes, reset values,
// configuration struct, front state encoding. No dependencies.
package mac_pkg;

    localparam int CFG_W    = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int DUR_W    = 32;
    localparam int INT_W    = 16;
    localparam int OUT_BITS = 3 + 2 * DUR_W + INT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [1:0] REG_MOVE_THR = 2'd0;
    localparam logic [1:0] REG_GRAZ_THR = 2'd1;
    localparam logic [1:0] REG_GRAVITY  = 2'd2;

    localparam logic [CFG_W-1:0] MOVE_THR_RST = 16'd512;
    localparam logic [CFG_W-1:0] GRAZ_THR_RST = 16'd128;
    localparam logic [CFG_W-1:0] GRAVITY_RST  = 16'd2509;

    typedef struct packed {
        logic [CFG_W-1:0] move_thr;
        logic [CFG_W-1:0] grazing_threshold;
        logic [CFG_W-1:0] gravity_level;
    } cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQUARE,
        F_SUM,
        F_ROOT,
        F_PUSH
    } front_state_t;

endpackage

// ===== rtl/mac_front.sv =====
// Front end: accepts a sample, squares the axes and takes the integer
// square root one bit per cycle. Depends on mac_pkg.
module mac_front
    import mac_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [SAMPLE_WIDTH-1:0]              accel_x,
    input  logic [SAMPLE_WIDTH-1:0]              accel_y,
    input  logic [SAMPLE_WIDTH-1:0]              accel_z,
    input  logic [TIME_WIDTH-1:0]                sample_time,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output logic [SAMPLE_WIDTH+TIME_WIDTH-1:0]   push_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int RW = 2 * SAMPLE_WIDTH;
    localparam int CW = $clog2(SAMPLE_WIDTH + 1);

    front_state_t state_reg, state_next;

    logic [SW-1:0] ax_reg, ay_reg, az_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [RW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [RW-1:0] rad_reg;
    logic [SW+1:0] rem_reg;
    logic [SW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;

    logic [SW+1:0] rem_sh, trial;
    logic          ge;
    logic          last_bit;

    function automatic logic [SW-1:0] abs_val(input logic [SW-1:0] v);
        return v[SW-1] ? (~v + 1'b1) : v;
    endfunction

    assign rem_sh   = {rem_reg[SW-1:0], rad_reg[RW-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign ge       = rem_sh >= trial;
    assign last_bit = cnt_reg == CW'(SW - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = F_SQUARE;
                end
            end
            F_SQUARE: state_next = F_SUM;
            F_SUM:    state_next = F_ROOT;
            F_ROOT: begin
                if (last_bit) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && in_valid) begin
            ax_reg   <= abs_val(accel_x);
            ay_reg   <= abs_val(accel_y);
            az_reg   <= abs_val(accel_z);
            time_reg <= sample_time;
        end
        if (state_reg == F_SQUARE) begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
            sqz_reg <= az_reg * az_reg;
        end
        if (state_reg == F_SUM) begin
            rad_reg  <= sqx_reg + sqy_reg + sqz_reg;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        if (state_reg == F_ROOT) begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[SW-2:0], ge};
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    assign push_data = {root_reg, time_reg};

endmodule

// ===== rtl/mac_fifo.sv =====
// Two-entry queue between the root front end and the classifier back end.
// Depends on mac_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mac_fifo
    import mac_pkg::*;
#(
    parameter int DW = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  logic [DW-1:0] wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_wr, do_rd;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    `MAC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= 2'd2, "queue count overflow")
    `MAC_ASSERT(a_ptr_match, aclk, aresetn, (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree with count")

endmodule

// ===== rtl/mac_back.sv =====
// Back end: intensity from magnitude, activity state update, output register.
// Depends on mac_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mac_back
    import mac_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cfg_t                                cfg,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [SAMPLE_WIDTH+TIME_WIDTH-1:0]  q_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [OUT_W-1:0]                    out_data
);

    localparam int EW = (SAMPLE_WIDTH > INT_W) ? SAMPLE_WIDTH : INT_W;
    localparam int TW = TIME_WIDTH;

    logic [SAMPLE_WIDTH-1:0] mag;
    logic [TW-1:0]           now;
    logic [EW-1:0]           mag_e, grav_e, diff;
    logic [INT_W-1:0]        sat;

    logic             pend_reg;
    logic [INT_W-1:0] int_reg;
    logic [TW-1:0]    now_reg;

    logic          moving_reg, grazing_reg, resting_reg;
    logic [TW-1:0] start_reg, move_kept_reg, rest_kept_reg;
    logic          out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic          fire2, mov, graz, rest_eff, graz_eff, moving_eff;
    logic [TW-1:0] start_eff, move_next, rest_next;

    assign {mag, now} = q_data;
    assign mag_e  = EW'(mag);
    assign grav_e = EW'(cfg.gravity_level);
    assign diff   = (mag_e >= grav_e) ? (mag_e - grav_e) : (grav_e - mag_e);
    assign sat    = (diff > EW'({INT_W{1'b1}})) ? {INT_W{1'b1}} : diff[INT_W-1:0];

    assign fire2   = pend_reg && (!out_valid_reg || out_ready);
    assign q_ready = !pend_reg || fire2;

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            int_reg <= sat;
            now_reg <= now;
        end
    end

    // activity update
    always_comb begin
        mov        = int_reg > cfg.move_thr;
        graz       = int_reg > cfg.grazing_threshold;
        start_eff  = start_reg;
        moving_eff = moving_reg;
        graz_eff   = grazing_reg;
        rest_eff   = resting_reg;
        move_next  = move_kept_reg;
        rest_next  = rest_kept_reg;
        if (mov) begin
            if (!moving_reg) begin
                start_eff = now_reg;
                graz_eff  = 1'b0;
                rest_eff  = 1'b0;
            end
            moving_eff = 1'b1;
            move_next  = now_reg - start_eff;
        end else begin
            if (moving_reg) begin
                graz_eff = graz;
                rest_eff = !graz;
            end
            moving_eff = 1'b0;
            if (rest_eff) begin
                rest_next = now_reg - start_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            moving_reg    <= 1'b0;
            grazing_reg   <= 1'b0;
            resting_reg   <= 1'b1;
            start_reg     <= '0;
            move_kept_reg <= '0;
            rest_kept_reg <= '0;
        end else begin
            if (q_valid && q_ready) begin
                pend_reg <= 1'b1;
            end else if (fire2) begin
                pend_reg <= 1'b0;
            end
            if (fire2) begin
                out_valid_reg <= 1'b1;
                moving_reg    <= moving_eff;
                grazing_reg   <= graz_eff;
                resting_reg   <= rest_eff;
                start_reg     <= start_eff;
                move_kept_reg <= move_next;
                rest_kept_reg <= rest_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire2) begin
            out_data_reg <= OUT_W'({int_reg, DUR_W'(rest_next), DUR_W'(move_next),
                                    rest_eff, graz_eff, moving_eff});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MAC_ASSERT(a_flags_onehot, aclk, aresetn, $onehot({moving_reg, grazing_reg, resting_reg}), "activity flags not one-hot")
    `MAC_ASSERT(a_move_entry_zero, aclk, aresetn, $rose(moving_reg) |-> (move_kept_reg == '0), "movement duration not cleared on entry")

endmodule

// ===== rtl/motion_activity_classifier.sv =====
// The front end takes a new sample only after pushing the last one to the queue; its
// bit-serial square root produces one root bit per cycle.
// Reset (aresetn low, synchronous): registers to defaults, resting state, times zero.
// Depends on mac_pkg, mac_front, mac_fifo, mac_back.
module motion_activity_classifier
    import mac_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x, accel_y, accel_z, sample_time, zero pad (low bit up)
    input  logic [((3*SAMPLE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // moving flag, grazing flag, resting flag, move_duration, rest time,
    // intensity, zero pad (low bit up)
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam int QW = SW + TW;

    cfg_t cfg_reg;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    logic [QW-1:0] push_data, pop_data;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_thr          <= MOVE_THR_RST;
            cfg_reg.grazing_threshold <= GRAZ_THR_RST;
            cfg_reg.gravity_level     <= GRAVITY_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_MOVE_THR: cfg_reg.move_thr          <= pwdata[CFG_W-1:0];
                REG_GRAZ_THR: cfg_reg.grazing_threshold <= pwdata[CFG_W-1:0];
                REG_GRAVITY:  cfg_reg.gravity_level     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MOVE_THR: prdata = APB_DW'(cfg_reg.move_thr);
            REG_GRAZ_THR: prdata = APB_DW'(cfg_reg.grazing_threshold);
            REG_GRAVITY:  prdata = APB_DW'(cfg_reg.gravity_level);
            default:      prdata = '0;
        endcase
    end

    mac_front #(
        .SAMPLE_WIDTH(SW),
        .TIME_WIDTH  (TW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .accel_x    (s_tdata[SW-1:0]),
        .accel_y    (s_tdata[2*SW-1:SW]),
        .accel_z    (s_tdata[3*SW-1:2*SW]),
        .sample_time(s_tdata[3*SW+TW-1:3*SW]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mac_fifo #(
        .DW(QW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data (push_data),
        .rd_valid(pop_valid),
        .rd_ready(pop_ready),
        .rd_data (pop_data)
    );

    mac_back #(
        .SAMPLE_WIDTH(SW),
        .TIME_WIDTH  (TW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_data   (pop_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

endmodule
